[hdl/timer_min_heap_scheduler_core_defines.svh]
// Assertion macros shared by the checker of the timer heap scheduler.
// No dependencies.
`ifndef TIMER_MIN_HEAP_SCHEDULER_CORE_DEFINES_SVH
`define TIMER_MIN_HEAP_SCHEDULER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define TMH_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Signal must hold while a condition stays true into the next cycle.
`define TMH_HOLD(label, clk, rst_n, cond, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(cond) |=> $stable(sig)) else $error(msg);
`endif

[hdl/tmh_pkg.sv]
// Package for the timer heap scheduler: widths, command and status codes.
// No dependencies.
package tmh_pkg;
	localparam int Capacity = 32;
	localparam int IdSpace = 64;
	localparam int SlotW = 5;
	localparam int CountW = 6;
	localparam int IdW = 6;
	localparam int TimeW = 48;
	localparam int DelayW = 20;
	localparam logic [2:0] KIND_ADD = 3'd0;
	localparam logic [2:0] KIND_ADJUST = 3'd1;
	localparam logic [2:0] KIND_FIRE = 3'd2;
	localparam logic [2:0] KIND_TICK = 3'd3;
	localparam logic [2:0] KIND_CLEAR = 3'd4;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_ID = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [DelayW-1:0] DelayMax = {DelayW{1'b1}};
endpackage

[hdl/timer_min_heap_scheduler_core.sv]
// Timer queue as a binary min-heap with an id-to-slot map and a millisecond clock.
// A tick removes and reports each fired timer in turn. One command at a time: the next
// is taken once the result is out.
// Reset clears the count, the presence bits and the clock; heap contents stay undefined.
module timer_min_heap_scheduler_core import tmh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        kind,
	input  logic [IdW-1:0]    timer_id,
	input  logic [19:0]       timeout_ms,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              fired_valid,
	output logic [IdW-1:0]    fired_id,
	output logic              next_valid,
	output logic [DelayW-1:0] next_delay_ms,
	output logic [1:0]        status,
	output logic              last
);
	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_DISP   = 10'b0000000010,
		S_DRD    = 10'b0000000100,
		S_DCMP   = 10'b0000001000,
		S_URD    = 10'b0000010000,
		S_UCMP   = 10'b0000100000,
		S_TICK   = 10'b0001000000,
		S_TCHK   = 10'b0010000000,
		S_OUT    = 10'b0100000000,
		S_DEL    = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [IdW-1:0]   ids_q [Capacity];
	logic [TimeW-1:0] exp_q [Capacity];
	logic [SlotW-1:0] pos_q [IdSpace];
	logic [IdSpace-1:0] present_q;
	logic [CountW-1:0] count_q;
	logic [TimeW-1:0] now_q;

	logic [2:0] kind_q;
	logic [IdW-1:0] id_q;
	logic [TimeW-1:0] expiry_q;
	logic [SlotW-1:0] cur_q, start_q;
	logic [CountW-1:0] lim_q;
	logic up_after_q, tick_q;
	logic [CountW-1:0] fired_q;

	// Shared compare unit operands, loaded by the sequencer.
	logic [TimeW-1:0] ea_q, eb_q, ec_q;
	logic [SlotW-1:0] ca_q, cb_q;
	logic has_b_q, has_a_q;

	logic [CountW-1:0] c1_w;
	logic b_lt_a, cur_lt;
	logic [SlotW-1:0] child_w;
	logic [TimeW-1:0] child_e;
	logic fire_w, out_set_w;

	logic ovalid_q, ofv_q, onv_q, olast_q;
	logic [IdW-1:0] ofid_q;
	logic [DelayW-1:0] od_q;
	logic [1:0] ost_q;
	logic [TimeW-1:0] dly;

	assign c1_w = {cur_q, 1'b1};
	assign b_lt_a = has_b_q && (eb_q < ea_q);
	assign child_w = b_lt_a ? cb_q : ca_q;
	assign child_e = b_lt_a ? eb_q : ea_q;
	assign cur_lt = ec_q < child_e;
	assign dly = exp_q[0] - now_q;
	assign fire_w = (count_q != '0) && (fired_q != CountW'(Capacity)) && (exp_q[0] <= now_q);
	assign out_set_w = ((state_q == S_OUT) || (state_q == S_TCHK && fire_w))
		&& (!ovalid_q || !out_stall);

	// A result still waiting on the output holds off the next command.
	assign in_stall = (state_q != S_IDLE) || (ovalid_q && out_stall);
	assign out_valid = ovalid_q;
	assign fired_valid = ofv_q;
	assign fired_id = ofid_q;
	assign next_valid = onv_q;
	assign next_delay_ms = od_q;
	assign status = ost_q;
	assign last = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			present_q <= '0;
			count_q <= '0;
			now_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			ovalid_q <= out_set_w || (ovalid_q && out_stall);
			case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						kind_q <= kind;
						id_q <= timer_id;
						expiry_q <= now_q + {{(TimeW-20){1'b0}}, timeout_ms};
						tick_q <= 1'b0;
						fired_q <= '0;
						if (kind == KIND_TICK) begin
							now_q <= now_q + 1'b1;
						end
						state_q <= S_DISP;
						ofv_q <= 1'b0;
						ofid_q <= '0;
						onv_q <= 1'b0;
						od_q <= '0;
						ost_q <= ST_OK;
						olast_q <= 1'b1;
						// Registered lookup of the addressed slot and its presence.
						cur_q <= pos_q[timer_id];
						up_after_q <= present_q[timer_id];
					end
				end
				S_DISP: begin
					lim_q <= count_q;
					start_q <= cur_q;
					case (kind_q)
						KIND_ADD: begin
							if (up_after_q) begin
								exp_q[cur_q] <= expiry_q;
								ec_q <= expiry_q;
								state_q <= S_DRD;
							end else if (count_q == CountW'(Capacity)) begin
								ost_q <= ST_FULL;
								state_q <= S_OUT;
							end else begin
								ids_q[count_q[SlotW-1:0]] <= id_q;
								exp_q[count_q[SlotW-1:0]] <= expiry_q;
								pos_q[id_q] <= count_q[SlotW-1:0];
								present_q[id_q] <= 1'b1;
								count_q <= count_q + 1'b1;
								cur_q <= count_q[SlotW-1:0];
								ec_q <= expiry_q;
								state_q <= S_URD;
							end
						end
						KIND_ADJUST: begin
							if (!up_after_q) begin
								ost_q <= ST_NO_ID;
								state_q <= S_OUT;
							end else begin
								exp_q[cur_q] <= expiry_q;
								ec_q <= expiry_q;
								up_after_q <= 1'b0;
								state_q <= S_DRD;
							end
						end
						KIND_FIRE: begin
							if (!up_after_q) begin
								ost_q <= ST_NO_ID;
								state_q <= S_OUT;
							end else begin
								ofv_q <= 1'b1;
								ofid_q <= id_q;
								state_q <= S_DEL;
							end
						end
						KIND_TICK: begin
							tick_q <= 1'b1;
							state_q <= S_TCHK;
						end
						KIND_CLEAR: begin
							present_q <= '0;
							count_q <= '0;
							state_q <= S_OUT;
						end
						default: begin
							state_q <= S_OUT;
						end
					endcase
				end
				S_DEL: begin
					// Move the tail into the vacated slot, then sift it.
					present_q[ids_q[cur_q]] <= 1'b0;
					lim_q <= count_q - 1'b1;
					count_q <= count_q - 1'b1;
					if ({1'b0, cur_q} < count_q - 1'b1) begin
						ids_q[cur_q] <= ids_q[count_q[SlotW-1:0] - 1'b1];
						exp_q[cur_q] <= exp_q[count_q[SlotW-1:0] - 1'b1];
						pos_q[ids_q[count_q[SlotW-1:0] - 1'b1]] <= cur_q;
						ec_q <= exp_q[count_q[SlotW-1:0] - 1'b1];
						start_q <= cur_q;
						up_after_q <= 1'b1;
						state_q <= S_DRD;
					end else begin
						state_q <= tick_q ? S_TCHK : S_OUT;
					end
				end
				S_DRD: begin
					has_a_q <= {1'b0, c1_w} < {1'b0, lim_q};
					has_b_q <= ({1'b0, c1_w} + 1'b1) < {1'b0, lim_q};
					ca_q <= c1_w[SlotW-1:0];
					cb_q <= c1_w[SlotW-1:0] + 1'b1;
					ea_q <= exp_q[c1_w[SlotW-1:0]];
					eb_q <= exp_q[c1_w[SlotW-1:0] + 1'b1];
					state_q <= S_DCMP;
				end
				S_DCMP: begin
					if (!has_a_q || cur_lt) begin
						if (up_after_q && cur_q == start_q) begin
							state_q <= S_URD;
						end else begin
							state_q <= tick_q ? S_TCHK : S_OUT;
						end
					end else begin
						ids_q[cur_q] <= ids_q[child_w];
						exp_q[cur_q] <= child_e;
						pos_q[ids_q[child_w]] <= cur_q;
						ids_q[child_w] <= ids_q[cur_q];
						exp_q[child_w] <= ec_q;
						pos_q[ids_q[cur_q]] <= child_w;
						cur_q <= child_w;
						state_q <= S_DRD;
					end
				end
				S_URD: begin
					ea_q <= exp_q[(cur_q - 1'b1) >> 1];
					ca_q <= (cur_q - 1'b1) >> 1;
					state_q <= S_UCMP;
				end
				S_UCMP: begin
					if (cur_q == '0 || ea_q < ec_q) begin
						state_q <= tick_q ? S_TCHK : S_OUT;
					end else begin
						ids_q[cur_q] <= ids_q[ca_q];
						exp_q[cur_q] <= ea_q;
						pos_q[ids_q[ca_q]] <= cur_q;
						ids_q[ca_q] <= ids_q[cur_q];
						exp_q[ca_q] <= ec_q;
						pos_q[ids_q[cur_q]] <= ca_q;
						cur_q <= ca_q;
						state_q <= S_URD;
					end
				end
				S_TCHK: begin
					if (!ovalid_q || !out_stall) begin
						if (fire_w) begin
							ofv_q <= 1'b1;
							ofid_q <= ids_q[0];
							onv_q <= 1'b0;
							od_q <= '0;
							olast_q <= 1'b0;
							fired_q <= fired_q + 1'b1;
							cur_q <= '0;
							state_q <= S_TICK;
						end else begin
							ofv_q <= 1'b0;
							ofid_q <= '0;
							olast_q <= 1'b1;
							onv_q <= (count_q != '0);
							if (count_q == '0) begin
								od_q <= '0;
							end else if (exp_q[0] <= now_q) begin
								od_q <= DelayW'(1);
							end else if (dly > TimeW'(DelayMax)) begin
								od_q <= DelayMax;
							end else begin
								od_q <= dly[DelayW-1:0];
							end
							state_q <= S_OUT;
						end
					end
				end
				S_TICK: begin
					state_q <= S_DEL;
				end
				S_OUT: begin
					if (!ovalid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[hdl/tmh_checker.sv]
// Port-level checker for the timer heap scheduler, bound to the top level.
// Depends on tmh_pkg and timer_min_heap_scheduler_core_defines.svh.
`include "timer_min_heap_scheduler_core_defines.svh"
module tmh_port_checker import tmh_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic fired_valid,
	input logic next_valid,
	input logic [1:0] status,
	input logic last
);
	`TMH_HOLD(a_out_hold, clk, arst_n, out_valid && out_stall, last, "result changed while stalled")
	`TMH_ASSERT(a_busy_after_take, clk, arst_n, in_valid && !in_stall |=> in_stall, "took a second command at once")
	`TMH_ASSERT(a_fire_not_last, clk, arst_n, out_valid && fired_valid && !last |-> status == ST_OK && !next_valid, "fired report carries closing fields")
	`TMH_ASSERT(a_status_code, clk, arst_n, out_valid |-> status != 2'd3, "undefined status code")
endmodule

bind timer_min_heap_scheduler_core tmh_port_checker u_tmh_port_checker (.*);

[bench/tmh_checker.sv]
// Checker for the timer heap scheduler: watches both channels, keeps its own
// heap of timers and compares every result transfer. Depends on tmh_pkg.
`timescale 1ns / 1ps
module tmh_checker import tmh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [2:0]        kind,
	input  logic [IdW-1:0]    timer_id,
	input  logic [19:0]       timeout_ms,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              fired_valid,
	input  logic [IdW-1:0]    fired_id,
	input  logic              next_valid,
	input  logic [DelayW-1:0] next_delay_ms,
	input  logic [1:0]        status,
	input  logic              last,
	output int                errors,
	output int                pending
);
	typedef struct packed {
		logic              fv;
		logic [IdW-1:0]    fid;
		logic              nv;
		logic [DelayW-1:0] delay;
		logic [1:0]        st;
		logic              lst;
	} timer_result_t;

	logic [IdW-1:0]   slot_id [Capacity];
	logic [TimeW-1:0] slot_exp [Capacity];
	int               slot_of [IdSpace];
	bit               held [IdSpace];
	int               fill;
	logic [TimeW-1:0] clock_ms;
	timer_result_t    awaited [$];

	function automatic void swap_slots(int a, int b);
		logic [IdW-1:0]   tid;
		logic [TimeW-1:0] tex;
		tid = slot_id[a];
		tex = slot_exp[a];
		slot_id[a] = slot_id[b];
		slot_exp[a] = slot_exp[b];
		slot_id[b] = tid;
		slot_exp[b] = tex;
		slot_of[slot_id[a]] = a;
		slot_of[slot_id[b]] = b;
	endfunction

	function automatic void bubble_up(int i);
		int p;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (slot_exp[p] < slot_exp[i])
				break;
			swap_slots(i, p);
			i = p;
		end
	endfunction

	function automatic bit bubble_down(int start, int n);
		int i;
		int c;
		i = start;
		c = 2 * i + 1;
		while (c < n) begin
			if (c + 1 < n && slot_exp[c + 1] < slot_exp[c])
				c++;
			if (slot_exp[i] < slot_exp[c])
				break;
			swap_slots(i, c);
			i = c;
			c = 2 * i + 1;
		end
		return i > start;
	endfunction

	function automatic void remove_slot(int i);
		int n;
		n = fill - 1;
		if (i < n) begin
			swap_slots(i, n);
			if (!bubble_down(i, n))
				bubble_up(i);
		end
		held[slot_id[n]] = 1'b0;
		fill = n;
	endfunction

	function automatic timer_result_t mk(logic fv, logic [IdW-1:0] fid, logic nv,
			logic [DelayW-1:0] d, logic [1:0] st, logic lst);
		timer_result_t r;
		r.fv = fv; r.fid = fid; r.nv = nv; r.delay = d; r.st = st; r.lst = lst;
		return r;
	endfunction

	// Appends one predicted result transfer to the tail of the queue.
	function automatic void add_result(logic fv, logic [IdW-1:0] fid, logic nv,
			logic [DelayW-1:0] d, logic [1:0] st, logic lst);
		awaited.insert(awaited.size(), mk(fv, fid, nv, d, st, lst));
	endfunction

	function automatic void apply_command(logic [2:0] k, logic [IdW-1:0] id,
			logic [19:0] tmo);
		logic [TimeW-1:0] due;
		logic [TimeW-1:0] gap;
		bit               known;
		int               pos;
		due = clock_ms + TimeW'(tmo);
		known = held[id];
		pos = known ? slot_of[id] : 0;
		case (k)
			KIND_ADD: begin
				if (known) begin
					slot_exp[pos] = due;
					if (!bubble_down(pos, fill))
						bubble_up(pos);
					add_result(1'b0, '0, 1'b0, '0, ST_OK, 1'b1);
				end else if (fill >= Capacity) begin
					add_result(1'b0, '0, 1'b0, '0, ST_FULL, 1'b1);
				end else begin
					slot_id[fill] = id;
					slot_exp[fill] = due;
					slot_of[id] = fill;
					held[id] = 1'b1;
					fill++;
					bubble_up(fill - 1);
					add_result(1'b0, '0, 1'b0, '0, ST_OK, 1'b1);
				end
			end
			KIND_ADJUST: begin
				if (!known) begin
					add_result(1'b0, '0, 1'b0, '0, ST_NO_ID, 1'b1);
				end else begin
					slot_exp[pos] = due;
					void'(bubble_down(pos, fill));
					add_result(1'b0, '0, 1'b0, '0, ST_OK, 1'b1);
				end
			end
			KIND_FIRE: begin
				if (!known) begin
					add_result(1'b0, '0, 1'b0, '0, ST_NO_ID, 1'b1);
				end else begin
					add_result(1'b1, id, 1'b0, '0, ST_OK, 1'b1);
					remove_slot(pos);
				end
			end
			KIND_TICK: begin
				clock_ms = clock_ms + 1'b1;
				while (fill > 0 && slot_exp[0] <= clock_ms) begin
					add_result(1'b1, slot_id[0], 1'b0, '0, ST_OK, 1'b0);
					remove_slot(0);
				end
				if (fill > 0) begin
					gap = slot_exp[0] > clock_ms ? slot_exp[0] - clock_ms : TimeW'(1);
					if (gap > TimeW'(DelayMax))
						gap = TimeW'(DelayMax);
					add_result(1'b0, '0, 1'b1, gap[DelayW-1:0], ST_OK, 1'b1);
				end else begin
					add_result(1'b0, '0, 1'b0, '0, ST_OK, 1'b1);
				end
			end
			KIND_CLEAR: begin
				foreach (held[j])
					held[j] = 1'b0;
				fill = 0;
				add_result(1'b0, '0, 1'b0, '0, ST_OK, 1'b1);
			end
			default: add_result(1'b0, '0, 1'b0, '0, ST_OK, 1'b1);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		timer_result_t seen;
		timer_result_t want;
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
			fill = 0;
			clock_ms = '0;
			foreach (held[j])
				held[j] = 1'b0;
			awaited.delete();
		end else begin
			if (in_valid && !in_stall)
				apply_command(kind, timer_id, timeout_ms);
			if (out_valid && !out_stall) begin
				seen = mk(fired_valid, fired_id, next_valid, next_delay_ms, status, last);
				if (awaited.size() == 0) begin
					$display("%0t: unexpected result transfer %p", $time, seen);
					errors <= errors + 1;
				end else begin
					want = awaited.pop_front();
					if (seen !== want) begin
						$display("%0t: result mismatch, expected %p, actual %p",
							$time, want, seen);
						errors <= errors + 1;
					end
				end
			end
			pending <= awaited.size();
		end
	end
endmodule

[bench/tb_timer_min_heap_scheduler_core.sv]
// Top of the timer heap scheduler testbench: clock, reset, stimulus and verdict.
// Depends on tmh_pkg, timer_min_heap_scheduler_core and tmh_checker.
`timescale 1ns / 1ps
module tb_timer_min_heap_scheduler_core;
	import tmh_pkg::*;

	localparam int IdleLimit = 20000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [2:0]        kind = '0;
	logic [IdW-1:0]    timer_id = '0;
	logic [19:0]       timeout_ms = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              fired_valid;
	logic [IdW-1:0]    fired_id;
	logic              next_valid;
	logic [DelayW-1:0] next_delay_ms;
	logic [1:0]        status;
	logic              last;
	int                errors;
	int                pending;
	int                idle_cycles = 0;

	always #6 clk = ~clk;

	timer_min_heap_scheduler_core dut (.*);
	tmh_checker chk (.*);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Receiver stalls; the first stretch of the run has no stall at all.
	initial begin
		int n;
		@(posedge arst_n);
		repeat (400) @(posedge clk);
		forever begin
			n = pick_gap();
			out_stall <= (n != 0);
			repeat (n > 0 ? n : $urandom_range(1, 20)) @(posedge clk);
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send(logic [2:0] k, logic [IdW-1:0] id, logic [19:0] tmo,
			bit gaps);
		int n;
		n = gaps ? pick_gap() : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		timer_id <= id;
		timeout_ms <= tmo;
		do @(posedge clk); while (in_stall);
	endtask

	initial begin
		int r;
		logic [2:0] k;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: empty tick, unknown ids, equal expiries, extremes, undefined kinds.
		send(KIND_TICK, 0, 0, 0);
		send(KIND_FIRE, 6'd63, 0, 0);
		send(KIND_ADJUST, 6'd0, 5, 0);
		send(KIND_ADD, 6'd0, 0, 0);
		send(KIND_ADD, 6'd63, 20'hFFFFF, 0);
		send(KIND_ADD, 6'd21, 2, 0);
		send(KIND_ADD, 6'd42, 2, 0);
		send(KIND_ADD, 6'd21, 3, 0);
		send(KIND_ADJUST, 6'd42, 1, 0);
		send(KIND_TICK, 0, 0, 0);
		send(KIND_TICK, 0, 0, 0);
		send(KIND_FIRE, 6'd63, 0, 0);
		send(3'd5, 6'd1, 20'h55555, 0);
		send(3'd6, 6'd2, 20'hAAAAA, 0);
		send(3'd7, 6'd3, 0, 0);
		// Fill the heap past capacity, then tick it all out at once.
		for (int i = 0; i < Capacity + 2; i++)
			send(KIND_ADD, IdW'(i), 1, 1);
		send(KIND_TICK, 0, 0, 1);
		send(KIND_CLEAR, 0, 0, 1);
		// Random: mostly adds with short timeouts and ticks, so timers fire.
		for (int i = 0; i < 400; i++) begin
			r = $urandom_range(0, 99);
			if (r < 35) k = KIND_ADD;
			else if (r < 50) k = KIND_ADJUST;
			else if (r < 62) k = KIND_FIRE;
			else if (r < 95) k = KIND_TICK;
			else if (r < 97) k = KIND_CLEAR;
			else k = 3'($urandom_range(5, 7));
			r = $urandom_range(0, 9);
			send(k, IdW'($urandom_range(0, r < 7 ? 39 : 63)),
				r == 0 ? 20'($urandom) : 20'($urandom_range(0, 12)), 1);
		end
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
